FILE: design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int NUM_DIGITS = 20;
   localparam int DIG_W      = 4 * NUM_DIGITS;
   localparam int VAL_W      = 64;
   localparam int HALF_W     = VAL_W / 2;

   localparam logic [1:0] CMD_SDEC = 2'd0;
   localparam logic [1:0] CMD_UDEC = 2'd1;
   localparam logic [1:0] CMD_LHEX = 2'd2;
   localparam logic [1:0] CMD_UHEX = 2'd3;

   localparam logic [6:0] CH_MINUS = 7'h2d;

   localparam logic [6:0] HEX_LOWER [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
   };
   localparam logic [6:0] HEX_UPPER [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   typedef struct packed {
      logic [1:0]       cmd;
      logic             wide;
      logic [VAL_W-1:0] value;
      logic [5:0]       width;
   } req_item_type;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic       load;
      logic [1:0] cmd;
      logic       wide;
   } conv_ctl_type;

   typedef struct packed {
      logic done;
      logic neg;
   } conv_sts_type;

   typedef struct packed {
      logic       load;
      logic       neg;
      logic       upper;
      logic [5:0] width;
   } emit_ctl_type;

   // add three to every BCD digit of five or more, ahead of the next shift
   function automatic logic [DIG_W-1:0] bcd_adjust(input logic [DIG_W-1:0] b);
      logic [DIG_W-1:0] r;
      logic [3:0]       d;
      r = b;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         d = b[4*i +: 4];
         if (d >= 4'd5) begin
            r[4*i +: 4] = d + 4'd3;
         end
      end
      return r;
   endfunction

endpackage

FILE: design/itoa_conv.sv
// ----------------------------------------------------------------------------
// itoa_conv
// Bit-serial magnitude to BCD converter; hex digits are loaded directly.
// ----------------------------------------------------------------------------
module itoa_conv
   import itoa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  conv_ctl_type     ctl,
   input  logic [VAL_W-1:0] value,
   output conv_sts_type     sts,
   output logic [DIG_W-1:0] digits
);

   logic [VAL_W-1:0]  mag_ff, mag_in;
   logic [DIG_W-1:0]  bcd_ff, bcd_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;

   logic              neg_w;
   logic [VAL_W-1:0]  mag_w;
   logic [HALF_W-1:0] mag32_w;
   logic [DIG_W-1:0]  adj_w;

   assign adj_w = bcd_adjust(bcd_ff);

   always_comb begin
      neg_w   = (ctl.cmd == CMD_SDEC) &&
                (ctl.wide ? value[VAL_W-1] : value[HALF_W-1]);
      mag32_w = neg_w ? (~value[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, 1'b1})
                      : value[HALF_W-1:0];
      if (ctl.wide) begin
         mag_w = neg_w ? (~value + {{(VAL_W-1){1'b0}}, 1'b1}) : value;
      end else begin
         mag_w = {{HALF_W{1'b0}}, mag32_w};
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (ctl.load) begin
         neg_in = neg_w;
         if (ctl.cmd == CMD_LHEX || ctl.cmd == CMD_UHEX) begin
            bcd_in  = {{(DIG_W-VAL_W){1'b0}}, mag_w};
            done_in = 1'b1;
         end else begin
            bcd_in = '0;
            run_in = 1'b1;
            if (ctl.wide) begin
               mag_in = mag_w;
               cnt_in = 7'(VAL_W);
            end else begin
               mag_in = {mag_w[HALF_W-1:0], {HALF_W{1'b0}}};
               cnt_in = 7'(HALF_W);
            end
         end
      end else if (run_ff) begin
         bcd_in = {adj_w[DIG_W-2:0], mag_ff[VAL_W-1]};
         mag_in = {mag_ff[VAL_W-2:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

   assign sts.done = done_ff;
   assign sts.neg  = neg_ff;
   assign digits   = bcd_ff;

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("conversion done while still shifting");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (cnt_ff != 7'd0 && cnt_ff <= 7'(VAL_W)))
      else $error("bit counter out of range while running");

endmodule

FILE: design/itoa_emit.sv
// ----------------------------------------------------------------------------
// itoa_emit
// Drops leading zeros, then shifts out sign and digits one character a cycle.
// ----------------------------------------------------------------------------
module itoa_emit
   import itoa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  emit_ctl_type     ctl,
   input  logic [DIG_W-1:0] digits,
   output logic             rsp_strobe,
   output rsp_item_type     rsp_item,
   output logic             done
);

   localparam logic [1:0] E_IDLE  = 2'd0;
   localparam logic [1:0] E_SKIP  = 2'd1;
   localparam logic [1:0] E_SIGN  = 2'd2;
   localparam logic [1:0] E_DIGIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [DIG_W-1:0] dig_ff, dig_in;
   logic [4:0]       left_ff, left_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             upper_ff, upper_in;
   logic [5:0]       width_ff, width_in;
   logic             strobe_ff, strobe_in;
   rsp_item_type     item_ff, item_in;
   logic             done_ff, done_in;

   logic             lim_hit;
   logic [3:0]       top_dig;

   assign top_dig = dig_ff[DIG_W-1 -: 4];
   assign lim_hit = (width_ff != 6'd0) && ((cnt_ff + 6'd1) == width_ff);

   always_comb begin
      state_in  = state_ff;
      dig_in    = dig_ff;
      left_in   = left_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      upper_in  = upper_ff;
      width_in  = width_ff;
      strobe_in = 1'b0;
      item_in   = '0;
      done_in   = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (ctl.load) begin
               dig_in   = digits;
               left_in  = 5'(NUM_DIGITS);
               cnt_in   = '0;
               neg_in   = ctl.neg;
               upper_in = ctl.upper;
               width_in = ctl.width;
               state_in = E_SKIP;
            end
         end
         E_SKIP: begin
            if (top_dig == 4'd0 && left_ff > 5'd1) begin
               dig_in  = {dig_ff[DIG_W-5:0], 4'd0};
               left_in = left_ff - 5'd1;
            end else begin
               state_in = neg_ff ? E_SIGN : E_DIGIT;
            end
         end
         E_SIGN: begin
            strobe_in    = 1'b1;
            item_in.ch   = CH_MINUS;
            item_in.last = lim_hit;
            cnt_in       = cnt_ff + 6'd1;
            if (lim_hit) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else begin
               state_in = E_DIGIT;
            end
         end
         E_DIGIT: begin
            strobe_in    = 1'b1;
            item_in.ch   = upper_ff ? HEX_UPPER[top_dig] : HEX_LOWER[top_dig];
            item_in.last = (left_ff == 5'd1) || lim_hit;
            dig_in       = {dig_ff[DIG_W-5:0], 4'd0};
            left_in      = left_ff - 5'd1;
            cnt_in       = cnt_ff + 6'd1;
            if (item_in.last) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= E_IDLE;
         strobe_ff <= 1'b0;
         done_ff   <= 1'b0;
         left_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         done_ff   <= done_in;
         left_ff   <= left_in;
         cnt_ff    <= cnt_in;
      end
      dig_ff   <= dig_in;
      neg_ff   <= neg_in;
      upper_ff <= upper_in;
      width_ff <= width_in;
      item_ff  <= item_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = item_ff;
   assign done       = done_ff;

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= 5'(NUM_DIGITS))
      else $error("digit count out of range");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      done_ff == (strobe_ff && item_ff.last))
      else $error("done does not match the last character");

endmodule

FILE: design/int_to_ascii_dec_hex.sv
// ----------------------------------------------------------------------------
// int_to_ascii_dec_hex
// Integer to ASCII converter: signed/unsigned decimal, lower/upper hex.
// ----------------------------------------------------------------------------
// One request at a time: an item is taken when start is high and busy low,
// and busy stays high until its last character is out. Decimal values run
// through a bit-serial binary to BCD shifter, one bit a cycle (32 bits in
// narrow mode, 64 in wide mode); hex values skip that step. Leading zeros
// are then dropped one digit a cycle (up to 19), and the characters follow
// one a cycle, most significant first, each on rsp_item for a single cycle
// with rsp_strobe high and last set on the final one. The receiver cannot
// stall. An item takes longer with a minus sign and less time when width
// cuts the text short.
// ----------------------------------------------------------------------------
module int_to_ascii_dec_hex
   import itoa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [5:0]       width_ff, width_in;

   logic             accept;
   conv_ctl_type     conv_ctl;
   conv_sts_type     conv_sts;
   emit_ctl_type     emit_ctl;
   logic [DIG_W-1:0] digits;
   logic             emit_done;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign conv_ctl.load = accept;
   assign conv_ctl.cmd  = req_item.cmd;
   assign conv_ctl.wide = req_item.wide;

   assign emit_ctl.load  = conv_sts.done;
   assign emit_ctl.neg   = conv_sts.neg;
   assign emit_ctl.upper = (cmd_ff == CMD_UHEX);
   assign emit_ctl.width = width_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      width_in = width_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_item.cmd;
               width_in = req_item.width;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (conv_sts.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff   <= cmd_in;
      width_ff <= width_in;
   end

   itoa_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (conv_ctl),
      .value  (req_item.value),
      .sts    (conv_sts),
      .digits (digits)
   );

   itoa_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .ctl        (emit_ctl),
      .digits     (digits),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .done       (emit_done)
   );

   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("character sent with no item in progress");

   a_conv_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_sts.done |-> (state_ff == S_CONV))
      else $error("conversion finished outside the conversion phase");

endmodule
